// File: hw/rtl/stq_pkg.sv
package stq_pkg;

   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int MAX_RESULTS     = 32;

   localparam logic [31:0] DEADLINE_MAX = 32'hFFFF_FFFE;

   // command codes
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_ARM    = 2'd1;
   localparam logic [1:0] CMD_CANCEL = 2'd2;

   // result status codes
   localparam logic [2:0] ST_NOTHING   = 3'd0;
   localparam logic [2:0] ST_EXPIRED   = 3'd1;
   localparam logic [2:0] ST_ARMED     = 3'd2;
   localparam logic [2:0] ST_CANCELLED = 3'd3;
   localparam logic [2:0] ST_NOTFOUND  = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  callback_id;
      logic [31:0] argument;
      logic [30:0] interval;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  out_callback;
      logic [31:0] out_argument;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_ZERO,
      IDX_LAST,
      IDX_INC,
      IDX_DEC
   } idx_op_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_SHIFT_UP,
      WR_SHIFT_DOWN,
      WR_PUT
   } wr_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_POP
   } cnt_op_type;

   typedef struct packed {
      logic       req_load;
      logic       tick_inc;
      idx_op_type idx_op;
      wr_op_type  wr_op;
      cnt_op_type cnt_op;
      logic       pos_load;
      logic       pos_zero;
      logic       pend_load;
      logic       rsp_load;
      logic [2:0] rsp_status;
      logic       rsp_last;
   } dp_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic full;
      logic head_due;
      logic greater;
      logic match;
      logic idx_zero;
      logic idx_last;
   } dp_sts_type;

endpackage

// File: hw/rtl/sorted_timeout_queue_core.sv
// Channel   Ports                         Word                Direction
// request   req_valid/req_ready/req_word  stq_pkg::req_type   in
// response  rsp_valid/rsp_ready/rsp_word  stq_pkg::rsp_type   out
//
// One command at a time; entries sit in one memory, walked one entry a cycle unless a stalled response holds a tick.
// A tick pops due entries from the head, up to MAX_RESULTS, one response word each;
// a cancel walks every entry; an arm walks down past each entry with a later deadline,
// and an arm on a full or empty queue skips the walk.
// Reset clears the tick count, fill count, head pointer and controller only.
// A stalled response holds its word; the next command is taken meanwhile.
module sorted_timeout_queue_core #(
   parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  stq_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output stq_pkg::rsp_type rsp_word
);

   stq_pkg::dp_cmd_type cmd;
   stq_pkg::dp_sts_type sts;

   stq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_word.command),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   stq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_word (rsp_word)
   );

   // a real command leaves the request side not ready in the cycle after it is taken
   a_busy_after_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_word.command == stq_pkg::CMD_TICK ||
       req_word.command == stq_pkg::CMD_ARM || req_word.command == stq_pkg::CMD_CANCEL))
      |=> !req_ready)
      else $error("request side ready right after a command");

   // while idle, any word still waiting is the final one of its command
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && req_ready) |-> rsp_word.last)
      else $error("idle with a non-final response pending");

   // a non-final word always means more expired words follow, never idle
   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_word.last) |-> !req_ready)
      else $error("idle before the final response of a tick");

   // only expired words carry a callback and argument, and never mark last early
   a_clean_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status != stq_pkg::ST_EXPIRED) |->
      (rsp_word.last && rsp_word.out_callback == 8'd0 && rsp_word.out_argument == 32'd0))
      else $error("status word with payload or without last");

endmodule

// File: hw/rtl/stq_datapath.sv
module stq_datapath #(
   parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  stq_pkg::req_type    req_word,
   input  stq_pkg::dp_cmd_type cmd,
   output stq_pkg::dp_sts_type sts,
   output stq_pkg::rsp_type    rsp_word
);

   localparam int PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int MEM_DEPTH = 1 << PTR_W;
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [31:0] deadline;
      logic [7:0]  callback;
      logic [31:0] argument;
   } entry_type;

   entry_type mem [MEM_DEPTH];

   logic [31:0]      tick_ff, tick_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] idx_ff, idx_in;
   logic [PTR_W-1:0] pos_ff, pos_in;
   entry_type        key_ff, key_in;
   entry_type        pend_ff, pend_in;
   entry_type        rd_data_ff;
   stq_pkg::rsp_type rsp_ff, rsp_in;

   logic [32:0]      sum;
   logic [31:0]      dl_new;
   logic [CNT_W-1:0] cnt_m1;
   logic [PTR_W-1:0] rd_addr;
   logic [PTR_W-1:0] wr_addr;
   entry_type        wr_data;
   logic             wr_en;

   assign sum    = {1'b0, tick_ff} + {2'b00, req_word.interval};
   assign dl_new = (sum > {1'b0, stq_pkg::DEADLINE_MAX}) ? stq_pkg::DEADLINE_MAX : sum[31:0];
   assign cnt_m1 = count_ff - CNT_W'(1);

   always_comb begin
      tick_in  = cmd.tick_inc ? tick_ff + 32'd1 : tick_ff;
      count_in = count_ff;
      head_in  = head_ff;
      case (cmd.cnt_op)
         stq_pkg::CNT_INC: count_in = count_ff + CNT_W'(1);
         stq_pkg::CNT_DEC: count_in = cnt_m1;
         stq_pkg::CNT_POP: begin
            count_in = cnt_m1;
            head_in  = head_ff + PTR_W'(1);
         end
         default: ;
      endcase

      idx_in = idx_ff;
      case (cmd.idx_op)
         stq_pkg::IDX_ZERO: idx_in = '0;
         stq_pkg::IDX_LAST: idx_in = cnt_m1[PTR_W-1:0];
         stq_pkg::IDX_INC:  idx_in = idx_ff + PTR_W'(1);
         stq_pkg::IDX_DEC:  idx_in = idx_ff - PTR_W'(1);
         default: ;
      endcase

      pos_in = pos_ff;
      if (cmd.pos_load) begin
         pos_in = cmd.pos_zero ? '0 : idx_ff + PTR_W'(1);
      end

      key_in = key_ff;
      if (cmd.req_load) begin
         key_in.deadline = dl_new;
         key_in.callback = req_word.callback_id;
         key_in.argument = req_word.argument;
      end

      pend_in = cmd.pend_load ? rd_data_ff : pend_ff;

      rsp_in = rsp_ff;
      if (cmd.rsp_load) begin
         rsp_in.status = cmd.rsp_status;
         rsp_in.last   = cmd.rsp_last;
         if (cmd.rsp_status == stq_pkg::ST_EXPIRED) begin
            rsp_in.out_callback = pend_ff.callback;
            rsp_in.out_argument = pend_ff.argument;
         end else begin
            rsp_in.out_callback = '0;
            rsp_in.out_argument = '0;
         end
      end
   end

   // read the entry that idx will point at next cycle
   assign rd_addr = head_in + idx_in;

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = head_ff + pos_ff;
      wr_data = rd_data_ff;
      case (cmd.wr_op)
         stq_pkg::WR_SHIFT_UP:   wr_addr = head_ff + idx_ff + PTR_W'(1);
         stq_pkg::WR_SHIFT_DOWN: wr_addr = head_ff + idx_ff - PTR_W'(1);
         stq_pkg::WR_PUT:        wr_data = key_ff;
         default:                wr_en   = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff  <= '0;
         count_ff <= '0;
         head_ff  <= '0;
      end else begin
         tick_ff  <= tick_in;
         count_ff <= count_in;
         head_ff  <= head_in;
      end
      idx_ff  <= idx_in;
      pos_ff  <= pos_in;
      key_ff  <= key_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign sts.count_zero = (count_ff == '0);
   assign sts.full       = (count_ff >= CNT_W'(QUEUE_DEPTH));
   assign sts.head_due   = (rd_data_ff.deadline <= tick_ff);
   assign sts.greater    = (rd_data_ff.deadline > key_ff.deadline);
   assign sts.match      = (rd_data_ff.callback == key_ff.callback) &&
                           (rd_data_ff.argument == key_ff.argument);
   assign sts.idx_zero   = (idx_ff == '0);
   assign sts.idx_last   = (idx_ff == cnt_m1[PTR_W-1:0]);

   assign rsp_word = rsp_ff;

endmodule

// File: hw/rtl/stq_ctrl.sv
module stq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_command,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  stq_pkg::dp_sts_type sts,
   output stq_pkg::dp_cmd_type cmd
);

   localparam int N_W = $clog2(stq_pkg::MAX_RESULTS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_TICK,
      S_ARM_WALK,
      S_ARM_PUT,
      S_CAN_WALK,
      S_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       fin_ff, fin_in;
   logic             found_ff, found_in;
   logic             have_pend_ff, have_pend_in;
   logic [N_W-1:0]   n_ff, n_in;

   logic slot_free;
   logic due;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign due       = !sts.count_zero && sts.head_due &&
                      (n_ff < N_W'(stq_pkg::MAX_RESULTS));

   always_comb begin
      state_in     = state_ff;
      fin_in       = fin_ff;
      found_in     = found_ff;
      have_pend_in = have_pend_ff;
      n_in         = n_ff;

      cmd.req_load   = 1'b0;
      cmd.tick_inc   = 1'b0;
      cmd.idx_op     = stq_pkg::IDX_HOLD;
      cmd.wr_op      = stq_pkg::WR_NONE;
      cmd.cnt_op     = stq_pkg::CNT_HOLD;
      cmd.pos_load   = 1'b0;
      cmd.pos_zero   = 1'b0;
      cmd.pend_load  = 1'b0;
      cmd.rsp_load   = 1'b0;
      cmd.rsp_status = stq_pkg::ST_NOTHING;
      cmd.rsp_last   = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_command)
                  stq_pkg::CMD_TICK: begin
                     cmd.tick_inc = 1'b1;
                     cmd.idx_op   = stq_pkg::IDX_ZERO;
                     n_in         = '0;
                     have_pend_in = 1'b0;
                     state_in     = S_TICK;
                  end
                  stq_pkg::CMD_ARM: begin
                     if (sts.full) begin
                        fin_in   = stq_pkg::ST_FULL;
                        state_in = S_FINISH;
                     end else if (sts.count_zero) begin
                        cmd.req_load = 1'b1;
                        cmd.pos_load = 1'b1;
                        cmd.pos_zero = 1'b1;
                        state_in     = S_ARM_PUT;
                     end else begin
                        cmd.req_load = 1'b1;
                        cmd.idx_op   = stq_pkg::IDX_LAST;
                        state_in     = S_ARM_WALK;
                     end
                  end
                  stq_pkg::CMD_CANCEL: begin
                     if (sts.count_zero) begin
                        fin_in   = stq_pkg::ST_NOTFOUND;
                        state_in = S_FINISH;
                     end else begin
                        cmd.req_load = 1'b1;
                        cmd.idx_op   = stq_pkg::IDX_ZERO;
                        found_in     = 1'b0;
                        state_in     = S_CAN_WALK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_TICK: begin
            // hold one popped entry back until we know whether another follows
            if (!have_pend_ff) begin
               if (due) begin
                  cmd.pend_load = 1'b1;
                  cmd.cnt_op    = stq_pkg::CNT_POP;
                  n_in          = n_ff + N_W'(1);
                  have_pend_in  = 1'b1;
               end else begin
                  fin_in   = stq_pkg::ST_NOTHING;
                  state_in = S_FINISH;
               end
            end else if (slot_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = stq_pkg::ST_EXPIRED;
               cmd.rsp_last   = !due;
               if (due) begin
                  cmd.pend_load = 1'b1;
                  cmd.cnt_op    = stq_pkg::CNT_POP;
                  n_in          = n_ff + N_W'(1);
               end else begin
                  have_pend_in = 1'b0;
                  state_in     = S_IDLE;
               end
            end
         end
         S_ARM_WALK: begin
            // walk down from the tail, moving later deadlines up one slot
            if (sts.greater) begin
               cmd.wr_op = stq_pkg::WR_SHIFT_UP;
               if (sts.idx_zero) begin
                  cmd.pos_load = 1'b1;
                  cmd.pos_zero = 1'b1;
                  state_in     = S_ARM_PUT;
               end else begin
                  cmd.idx_op = stq_pkg::IDX_DEC;
               end
            end else begin
               cmd.pos_load = 1'b1;
               state_in     = S_ARM_PUT;
            end
         end
         S_ARM_PUT: begin
            cmd.wr_op  = stq_pkg::WR_PUT;
            cmd.cnt_op = stq_pkg::CNT_INC;
            fin_in     = stq_pkg::ST_ARMED;
            state_in   = S_FINISH;
         end
         S_CAN_WALK: begin
            // past the first match, close the gap one entry at a time
            if (found_ff) begin
               cmd.wr_op = stq_pkg::WR_SHIFT_DOWN;
            end else if (sts.match) begin
               found_in = 1'b1;
            end
            if (sts.idx_last) begin
               if (found_ff || sts.match) begin
                  cmd.cnt_op = stq_pkg::CNT_DEC;
                  fin_in     = stq_pkg::ST_CANCELLED;
               end else begin
                  fin_in = stq_pkg::ST_NOTFOUND;
               end
               state_in = S_FINISH;
            end else begin
               cmd.idx_op = stq_pkg::IDX_INC;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = fin_ff;
               cmd.rsp_last   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         fin_ff       <= stq_pkg::ST_NOTHING;
         found_ff     <= 1'b0;
         have_pend_ff <= 1'b0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fin_ff       <= fin_in;
         found_ff     <= found_in;
         have_pend_ff <= have_pend_in;
         n_ff         <= n_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
